/* rtl/iql_pkg.sv */
// Shared types and constants for the inverter quadratic loss curve unit.
// No dependencies; used by the top level, the checker and the testbench.
package iql_pkg;

  localparam int unsigned PowerW       = 24;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned PowerFracBits = 8;
  localparam int unsigned CoefFracBits  = 16;
  localparam int unsigned CfgIdxW      = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInK0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInK1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInK2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutK0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutK1  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutK2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNomPwr = 3'd6;

  localparam logic [CoefW-1:0] InK0Reset   = 16'd151;
  localparam logic [CoefW-1:0] InK1Reset   = 16'd675;
  localparam logic [CoefW-1:0] InK2Reset   = 16'd5951;
  localparam logic [CoefW-1:0] OutK0Reset  = 16'd177;
  localparam logic [CoefW-1:0] OutK1Reset  = 16'd1035;
  localparam logic [CoefW-1:0] OutK2Reset  = 16'd4057;
  localparam logic [CoefW-1:0] NomPwrReset = 16'd5000;

  typedef struct packed {
    logic              action;
    logic              curve;
    logic [PowerW-1:0] power_given;
  } in_item_t;

  typedef struct packed {
    logic [PowerW-1:0] power_result;
    logic              below_standby;
    logic              saturated;
  } out_item_t;

endpackage

/* rtl/iql_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Carries an opaque side vector alongside each item; no package needed.
module iql_div_pipe #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] vld_q;
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] dvs_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          cv;
    logic [DW-1:0] cr;
    logic [DW-1:0] cd;
    logic [NW-1:0] cn;
    logic [SW-1:0] cs;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign cv = valid_i;
      assign cr = rem_i;
      assign cd = div_i;
      assign cn = num_i;
      assign cs = side_i;
    end else begin : g_next
      assign cv = vld_q[i-1];
      assign cr = rem_q[i-1];
      assign cd = dvs_q[i-1];
      assign cn = num_q[i-1];
      assign cs = side_q[i-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {cr, cn[NW-1]};
    assign diff  = trial - {1'b0, cd};
    assign take  = ~diff[DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
      num_q[i]  <= {cn[NW-2:0], take};
      dvs_q[i]  <= cd;
      side_q[i] <= cs;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = num_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

/* rtl/iql_sqrt_pipe.sv */
// Pipelined 64-bit integer square root, one result bit per register stage.
// Carries an opaque side vector alongside each item; no package needed.
module iql_sqrt_pipe #(
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [63:0]   rad_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned Steps = 32;

  logic [Steps-1:0] vld_q;
  logic [63:0]      rad_q  [Steps];
  logic [63:0]      res_q  [Steps];
  logic [SW-1:0]    side_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic          cv;
    logic [63:0]   cr;
    logic [63:0]   cres;
    logic [SW-1:0] cs;
    logic [63:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign cv   = valid_i;
      assign cr   = rad_i;
      assign cres = '0;
      assign cs   = side_i;
    end else begin : g_next
      assign cv   = vld_q[i-1];
      assign cr   = rad_q[i-1];
      assign cres = res_q[i-1];
      assign cs   = side_q[i-1];
    end

    assign trial = cres + Bit;
    assign take  = (cr >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= take ? (cr - trial) : cr;
      res_q[i]  <= take ? ((cres >> 1) + Bit) : (cres >> 1);
      side_q[i] <= cs;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = res_q[Steps-1][31:0];
  assign side_o  = side_q[Steps-1];

endmodule

/* rtl/inverter_quadratic_loss_curve_unit.sv */
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls.
// Depth is set by the 64-step divider, the 32-step square root and the
// 24-step final divider, each one bit per stage. Reset clears all valid bits
// and loads the default coefficients; configuration writes take effect at once.
// Uses iql_pkg, iql_div_pipe and iql_sqrt_pipe.
module inverter_quadratic_loss_curve_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  iql_pkg::in_item_t       in_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output logic                    done_o,
  output iql_pkg::out_item_t      out_o
);
  import iql_pkg::*;

  localparam int unsigned Latency = 5 + 64 + 1 + 32 + 1 + 24 + 1;
  localparam logic [63:0] T1Lim   = 64'd1 << 40;
  localparam logic [42:0] RndHalf = 43'd1 << (CoefFracBits - 1);

  typedef struct packed {
    logic        action;
    logic        below;
    logic [16:0] b;
    logic [33:0] b2;
    logic [39:0] e;
    logic [41:0] base;
  } div1_side_t;

  typedef struct packed {
    logic        action;
    logic        below;
    logic [39:0] e;
    logic [16:0] b;
    logic [26:0] fres;
  } sqrt_side_t;

  typedef struct packed {
    logic        action;
    logic        below;
    logic        sat;
    logic [26:0] fres;
  } div2_side_t;

  // configuration registers
  logic [CoefW-1:0] in_k0_q, in_k1_q, in_k2_q, out_k0_q, out_k1_q, out_k2_q, nom_pwr_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_k0_q   <= InK0Reset;
      in_k1_q   <= InK1Reset;
      in_k2_q   <= InK2Reset;
      out_k0_q  <= OutK0Reset;
      out_k1_q  <= OutK1Reset;
      out_k2_q  <= OutK2Reset;
      nom_pwr_q <= NomPwrReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegInK0:   in_k0_q   <= cfg_data_i;
        RegInK1:   in_k1_q   <= cfg_data_i;
        RegInK2:   in_k2_q   <= cfg_data_i;
        RegOutK0:  out_k0_q  <= cfg_data_i;
        RegOutK1:  out_k1_q  <= cfg_data_i;
        RegOutK2:  out_k2_q  <= cfg_data_i;
        RegNomPwr: nom_pwr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: capture item and its coefficient set
  logic             v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic             act0_q;
  logic [23:0]      p0_q, m0_q;
  logic [CoefW-1:0] k0_0_q, k1_0_q, k2_0_q;
  logic [CoefW-1:0] pn;
  logic             accept;

  assign accept = start_i & ~busy_o;
  assign pn     = (nom_pwr_q == '0) ? 16'd1 : nom_pwr_q;

  // stage 1 products
  logic        act1_q;
  logic [23:0] p1_q, m1_q;
  logic [15:0] k2_1_q;
  logic [16:0] b1_q;
  logic [39:0] k2p1_q, k0m1_q;
  logic [40:0] bp1_q;
  logic [33:0] b2_1_q;

  // stage 2 standby split and operand select
  logic        act2_q, below2_q;
  logic [23:0] m2_q, opb2_q;
  logic [16:0] b2b_q;
  logic [33:0] b2_2_q;
  logic [39:0] e2_q, opa2_q;
  logic [41:0] base2_q;
  logic [39:0] pin1;

  assign pin1 = {p1_q, 16'h0000};

  // stage 3 partial products, stage 4 sum
  logic [43:0] hi3_q, lo3_q;
  logic [23:0] m3_q, m4_q;
  div1_side_t  side3_q, side4_q;
  logic [63:0] n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act0_q <= in_i.action;
    p0_q   <= in_i.power_given;
    m0_q   <= {pn, 8'h00};
    k0_0_q <= in_i.curve ? out_k0_q : in_k0_q;
    k1_0_q <= in_i.curve ? out_k1_q : in_k1_q;
    k2_0_q <= in_i.curve ? out_k2_q : in_k2_q;

    act1_q <= act0_q;
    p1_q   <= p0_q;
    m1_q   <= m0_q;
    k2_1_q <= k2_0_q;
    b1_q   <= {1'b1, k1_0_q};
    k2p1_q <= 40'(k2_0_q) * 40'(p0_q);
    k0m1_q <= 40'(k0_0_q) * 40'(m0_q);
    bp1_q  <= 41'({1'b1, k1_0_q}) * 41'(p0_q);
    b2_1_q <= 34'({1'b1, k1_0_q}) * 34'({1'b1, k1_0_q});

    act2_q   <= act1_q;
    below2_q <= ~act1_q & (pin1 < k0m1_q);
    e2_q     <= pin1 - k0m1_q;
    base2_q  <= 42'(bp1_q) + 42'(k0m1_q);
    m2_q     <= m1_q;
    b2b_q    <= b1_q;
    b2_2_q   <= b2_1_q;
    opa2_q   <= act1_q ? k2p1_q : (pin1 - k0m1_q);
    opb2_q   <= act1_q ? p1_q : {6'b0, k2_1_q, 2'b00};

    hi3_q          <= 44'(opa2_q[39:20]) * 44'(opb2_q);
    lo3_q          <= 44'(opa2_q[19:0]) * 44'(opb2_q);
    m3_q           <= m2_q;
    side3_q.action <= act2_q;
    side3_q.below  <= below2_q;
    side3_q.b      <= b2b_q;
    side3_q.b2     <= b2_2_q;
    side3_q.e      <= e2_q;
    side3_q.base   <= base2_q;

    n4_q    <= (64'(hi3_q) << 20) + 64'(lo3_q);
    m4_q    <= m3_q;
    side4_q <= side3_q;
  end

  // quadratic term divided by normalization
  logic        v_d1;
  logic [63:0] q1;
  div1_side_t  side_d1;

  iql_div_pipe #(
    .NW(64),
    .DW(24),
    .SW($bits(div1_side_t))
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rem_i   (24'd0),
    .num_i   (n4_q),
    .div_i   (m4_q),
    .side_i  (side4_q),
    .valid_o (v_d1),
    .quot_o  (q1),
    .side_o  (side_d1)
  );

  // stage 5: finish forward result, form discriminant
  logic [40:0] t1;
  logic [42:0] fsum;
  logic [63:0] disc5_q;
  sqrt_side_t  side5_q;

  assign t1   = (q1 > T1Lim) ? 41'(T1Lim) : q1[40:0];
  assign fsum = 43'(t1) + 43'(side_d1.base) + RndHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v_d1;
    end
  end

  always_ff @(posedge clk_i) begin
    disc5_q        <= 64'(side_d1.b2) + 64'(q1[57:0]);
    side5_q.action <= side_d1.action;
    side5_q.below  <= side_d1.below;
    side5_q.e      <= side_d1.e;
    side5_q.b      <= side_d1.b;
    side5_q.fres   <= fsum[42:16];
  end

  logic        v_sq;
  logic [31:0] root;
  sqrt_side_t  side_sq;

  iql_sqrt_pipe #(
    .SW($bits(sqrt_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (disc5_q),
    .side_i  (side5_q),
    .valid_o (v_sq),
    .root_o  (root),
    .side_o  (side_sq)
  );

  // stage 6: denominator and rounded numerator
  logic [30:0] den;
  logic [41:0] num;
  logic        ovf6;
  logic [30:0] den6_q, rem6_q;
  logic [23:0] num6_q;
  div2_side_t  side6_q;

  assign den  = 31'(side_sq.b) + 31'(root[29:0]);
  assign num  = 42'({side_sq.e, 1'b0}) + 42'(den >> 1);
  assign ovf6 = (31'(num[41:24]) >= den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v_sq;
    end
  end

  always_ff @(posedge clk_i) begin
    den6_q         <= den;
    rem6_q         <= ovf6 ? 31'd0 : 31'(num[41:24]);
    num6_q         <= num[23:0];
    side6_q.action <= side_sq.action;
    side6_q.below  <= side_sq.below;
    side6_q.sat    <= ovf6;
    side6_q.fres   <= side_sq.fres;
  end

  logic        v_d2;
  logic [23:0] q2;
  div2_side_t  side_d2;

  iql_div_pipe #(
    .NW(24),
    .DW(31),
    .SW($bits(div2_side_t))
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .rem_i   (rem6_q),
    .num_i   (num6_q),
    .div_i   (den6_q),
    .side_i  (side6_q),
    .valid_o (v_d2),
    .quot_o  (q2),
    .side_o  (side_d2)
  );

  // output register
  logic      done_q;
  out_item_t out_d, out_q;

  always_comb begin
    out_d = '0;
    if (side_d2.action) begin
      if (|side_d2.fres[26:24]) begin
        out_d.power_result = '1;
        out_d.saturated    = 1'b1;
      end else begin
        out_d.power_result = side_d2.fres[23:0];
      end
    end else if (side_d2.below) begin
      out_d.below_standby = 1'b1;
    end else if (side_d2.sat) begin
      out_d.power_result = '1;
      out_d.saturated    = 1'b1;
    end else begin
      out_d.power_result = q2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_d2;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef ASSERT_OFF
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("item result missing at fixed latency");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(out_o.below_standby && out_o.saturated))
    else $error("below_standby and saturated both set");

  a_standby_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.below_standby |-> out_o.power_result == '0)
    else $error("nonzero power under standby");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.saturated |-> out_o.power_result == '1)
    else $error("saturated result not at maximum");
`endif

endmodule

/* dv/iql_checker.sv */
// Checker for the inverter quadratic loss curve unit: watches the item, result
// and register write channels, predicts each result and compares it.
// Depends on iql_pkg for the item types, widths and register indexes.
module iql_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  iql_pkg::in_item_t  in_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               done_o,
  input  iql_pkg::out_item_t out_o,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import iql_pkg::*;

  logic [CoefW-1:0] coef_q [7];
  out_item_t        expected_q [$];

  function automatic out_item_t loss_curve_eval(in_item_t it);
    longint unsigned k0, k1, k2, pn, m, p, res, s, t1, e, b, qq, rr, a4;
    longint unsigned disc, term, den, v, root, bitv;
    longint unsigned one, lim, dmax;
    out_item_t o;
    one  = 64'd1 << CoefFracBits;
    dmax = 64'h3FFF_FFFF_FFFF_FFFF;
    k0 = it.curve ? coef_q[RegOutK0] : coef_q[RegInK0];
    k1 = it.curve ? coef_q[RegOutK1] : coef_q[RegInK1];
    k2 = it.curve ? coef_q[RegOutK2] : coef_q[RegInK2];
    pn = (coef_q[RegNomPwr] == 0) ? 64'd1 : 64'(coef_q[RegNomPwr]);
    m  = pn << PowerFracBits;
    p  = 64'(it.power_given);
    o  = '0;
    if (it.action) begin
      lim = 64'd1 << (PowerW + CoefFracBits);
      t1  = (k2 * p) * p / m;
      if (t1 > lim) t1 = lim;
      s   = t1 + (one + k1) * p + k0 * m;
      res = (s + (one >> 1)) >> CoefFracBits;
    end else if ((p << CoefFracBits) < k0 * m) begin
      o.below_standby = 1'b1;
      res = 0;
    end else begin
      e    = (p << CoefFracBits) - k0 * m;
      b    = one + k1;
      qq   = e / m;
      rr   = e % m;
      a4   = 4 * k2;
      disc = b * b;
      if (a4 != 0 && qq > dmax / a4) begin
        disc = dmax;
      end else begin
        term = a4 * qq + (a4 * rr) / m;
        disc = (term > dmax - disc) ? dmax : disc + term;
      end
      // integer square root, truncated
      v = disc;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v    = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      den = b + root;
      res = (2 * e + (den >> 1)) / den;
    end
    if (res > 64'hFF_FFFF) begin
      res = 64'hFF_FFFF;
      o.saturated = 1'b1;
    end
    o.power_result = res[PowerW-1:0];
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      coef_q[RegInK0]   <= InK0Reset;
      coef_q[RegInK1]   <= InK1Reset;
      coef_q[RegInK2]   <= InK2Reset;
      coef_q[RegOutK0]  <= OutK0Reset;
      coef_q[RegOutK1]  <= OutK1Reset;
      coef_q[RegOutK2]  <= OutK2Reset;
      coef_q[RegNomPwr] <= NomPwrReset;
      expected_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i <= RegNomPwr)
        coef_q[cfg_index_i] <= cfg_data_i;
      if (start_i && !busy_o)
        expected_q.push_back(loss_curve_eval(in_i));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding: %p", out_o);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_o.power_result !== want.power_result) begin
            $error("power_result expected %0d actual %0d", want.power_result,
                   out_o.power_result);
            errors_o <= errors_o + 1;
          end else if (out_o.below_standby !== want.below_standby) begin
            $error("below_standby expected %0b actual %0b", want.below_standby,
                   out_o.below_standby);
            errors_o <= errors_o + 1;
          end else if (out_o.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated,
                   out_o.saturated);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

/* dv/tb.sv */
// Top of the testbench: clock, reset, item and register write stimulus.
// Depends on iql_pkg, the unit under test and iql_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iql_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Drain      = 140;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  out_item_t   result;
  int unsigned pending, errors;
  int unsigned cycles = 0;
  int unsigned coef_shadow [7];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  inverter_quadratic_loss_curve_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .done_o(done), .out_o(result)
  );

  iql_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .done_o(done), .out_o(result),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // hold the item until the unit takes it; start stays high across gapless items
  task automatic send_item(input in_item_t it, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= RegNomPwr) coef_shadow[idx] = 32'(val);
    @(posedge clk);
  endtask

  // power near the standby threshold of the chosen curve
  function automatic logic [PowerW-1:0] standby_edge(logic crv, int signed offs);
    longint unsigned k0, pn, pw;
    k0 = crv ? coef_shadow[RegOutK0] : coef_shadow[RegInK0];
    pn = (coef_shadow[RegNomPwr] == 0) ? 1 : coef_shadow[RegNomPwr];
    pw = (k0 * pn) >> 8;
    if (offs < 0 && pw == 0) return '0;
    pw = longint'(pw) + offs;
    return (pw > 64'hFF_FFFF) ? {PowerW{1'b1}} : pw[PowerW-1:0];
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t    it;
    int unsigned gap, mode;
    coef_shadow = '{InK0Reset, InK1Reset, InK2Reset, OutK0Reset, OutK1Reset,
                    OutK2Reset, NomPwrReset};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both actions and curves, standby edges, overflow
    for (int a = 0; a < 2; a++) begin
      for (int c = 0; c < 2; c++) begin
        send_item('{action: a[0], curve: c[0], power_given: '0}, 0);
        send_item('{action: a[0], curve: c[0], power_given: {PowerW{1'b1}}}, 0);
        send_item('{action: a[0], curve: c[0],
                    power_given: standby_edge(c[0], 0)}, 1);
        send_item('{action: a[0], curve: c[0],
                    power_given: standby_edge(c[0], -1)}, 0);
        send_item('{action: a[0], curve: c[0],
                    power_given: standby_edge(c[0], 1)}, 2);
      end
    end
    drain_results();

    // zero nominal power, zero coefficients, then the maximum values
    for (int s = 0; s < 2; s++) begin
      for (int r = 0; r <= RegNomPwr; r++) write_reg(3'(r), s ? 16'hFFFF : 16'h0000);
      write_reg(3'd7, 16'h1234);
      for (int n = 0; n < 4; n++) begin
        send_item('{action: n[0], curve: n[1], power_given: {PowerW{1'b1}}}, 0);
        send_item('{action: n[0], curve: n[1], power_given: PowerW'(1)}, 0);
      end
      drain_results();
    end

    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r <= RegNomPwr; r++) begin
        if (ph == 0) begin
          write_reg(3'(r), (r == RegNomPwr) ? NomPwrReset : 16'd0);
          if (r == RegInK0) write_reg(3'(r), InK0Reset);
        end else begin
          write_reg(3'(r), rand_coef());
        end
      end
      mode = $urandom_range(0, 2);
      for (int n = 0; n < 240; n++) begin
        it.action = 1'($urandom_range(0, 1));
        it.curve  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0: it.power_given = standby_edge(it.curve, int'($urandom_range(0, 4)) - 2);
          1: it.power_given = PowerW'($urandom_range(0, 65535));
          default: it.power_given = PowerW'($urandom);
        endcase
        case (mode)
          0: gap = 0;
          1: gap = $urandom_range(0, 12);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        endcase
        send_item(it, gap);
      end
      drain_results();
    end

    repeat (Drain) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
